// ===== src/double_ended_queue_core_macros.svh =====
// ----------------------------------------------------------------------------
// Double-ended queue assertion macros
// Shorthand for clocked assertions that are held off during reset.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DEQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue package
// Word types, operation codes and status codes shared by the queue modules.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int VALUE_W     = 32;
  localparam int ITEM_CNT_W  = 5;

  typedef enum logic [1:0] {
    MODE_PUSH_BACK  = 2'd0,
    MODE_PUSH_FRONT = 2'd1,
    MODE_POP_BACK   = 2'd2,
    MODE_POP_FRONT  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    mode_t                      mode;
    logic signed [VALUE_W-1:0]  value;
  } deq_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  popped_value;
    status_t                    status;
    logic [ITEM_CNT_W-1:0]      item_count;
    logic                       is_empty;
  } deq_out_t;

  typedef struct packed {
    logic    wr_en;
    logic    rd_en;
    status_t status;
  } deq_op_t;

endpackage

// ===== src/double_ended_queue_core.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue core
// Bounded deque of signed 32-bit words held in a circular entry store.
// ----------------------------------------------------------------------------
// One word is accepted per cycle while the result side keeps up; each word
// yields one result word, held first in the stage-one registers beside the
// registered read of the single-port entry store and then in the output
// register. The front index and entry count update at acceptance, so
// consecutive operations need no forwarding. Entries are not cleared at
// reset, and the queue is ready in the first cycle after reset.
module double_ended_queue_core import deq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  deq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output deq_out_t out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  deq_op_t            op;
  logic [AW-1:0]      addr;
  logic [CW-1:0]      count_nxt;
  logic [VALUE_W-1:0] rd_data;
  logic               step;
  logic               out_free;
  logic               s1_adv;

  logic               s1_valid_r;
  logic               s1_pop_r;
  status_t            s1_status_r;
  logic [CW-1:0]      s1_count_r;
  logic               out_valid_r;
  deq_out_t           out_data_r;
  logic [CW+ITEM_CNT_W-1:0] count_ext;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign step     = in_valid && !in_stall;

  deq_ptr #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ptr (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .mode      (in_data.mode),
    .op        (op),
    .addr      (addr),
    .count_nxt (count_nxt)
  );

  deq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (op.wr_en),
    .rd_en   (step && op.rd_en),
    .addr    (addr),
    .wr_data (in_data.value),
    .rd_data (rd_data)
  );

  assign count_ext = {{ITEM_CNT_W{1'b0}}, s1_count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (step) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (step) begin
      s1_pop_r    <= op.rd_en;
      s1_status_r <= op.status;
      s1_count_r  <= count_nxt;
    end
    if (s1_adv) begin
      out_data_r.popped_value <= s1_pop_r ? rd_data : '0;
      out_data_r.status       <= s1_status_r;
      out_data_r.item_count   <= count_ext[ITEM_CNT_W-1:0];
      out_data_r.is_empty     <= (s1_count_r == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/deq_ram.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue entry store
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module deq_ram import deq_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic               rd_en,
  input  logic [AW-1:0]      addr,
  input  logic [VALUE_W-1:0] wr_data,
  output logic [VALUE_W-1:0] rd_data
);

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/deq_ptr.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue pointer control
// Holds the front index and entry count, decides each operation and
// drives the entry store address.
// ----------------------------------------------------------------------------
`include "double_ended_queue_core_macros.svh"

module deq_ptr import deq_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int CW    = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  mode_t         mode,
  output deq_op_t       op,
  output logic [AW-1:0] addr,
  output logic [CW-1:0] count_nxt
);

  localparam int SW = CW + 1;

  logic [AW-1:0] front_r;
  logic [AW-1:0] front_nxt;
  logic [CW-1:0] cnt_r;
  logic          full;
  logic          empty;
  logic [SW-1:0] sum_back;
  logic [SW-1:0] sum_last;
  logic [AW-1:0] back_pos;
  logic [AW-1:0] last_pos;
  logic [AW-1:0] front_dec;
  logic [AW-1:0] front_inc;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);

  assign sum_back  = SW'(front_r) + SW'(cnt_r);
  assign sum_last  = sum_back - SW'(1);
  assign back_pos  = (sum_back >= SW'(DEPTH)) ? AW'(sum_back - SW'(DEPTH)) : AW'(sum_back);
  assign last_pos  = (sum_last >= SW'(DEPTH)) ? AW'(sum_last - SW'(DEPTH)) : AW'(sum_last);
  assign front_dec = (front_r == '0) ? AW'(DEPTH - 1) : front_r - AW'(1);
  assign front_inc = (front_r == AW'(DEPTH - 1)) ? '0 : front_r + AW'(1);

  always_comb begin
    op        = '{wr_en: 1'b0, rd_en: 1'b0, status: STATUS_OK};
    addr      = front_r;
    front_nxt = front_r;
    count_nxt = cnt_r;
    unique case (mode)
      MODE_PUSH_BACK: begin
        if (full) begin
          op.status = STATUS_FULL;
        end else begin
          op.wr_en  = step;
          addr      = back_pos;
          count_nxt = cnt_r + CW'(1);
        end
      end
      MODE_PUSH_FRONT: begin
        if (full) begin
          op.status = STATUS_FULL;
        end else begin
          op.wr_en  = step;
          addr      = front_dec;
          front_nxt = front_dec;
          count_nxt = cnt_r + CW'(1);
        end
      end
      MODE_POP_BACK: begin
        if (empty) begin
          op.status = STATUS_EMPTY;
        end else begin
          op.rd_en  = 1'b1;
          addr      = last_pos;
          count_nxt = cnt_r - CW'(1);
        end
      end
      MODE_POP_FRONT: begin
        if (empty) begin
          op.status = STATUS_EMPTY;
        end else begin
          op.rd_en  = 1'b1;
          addr      = front_r;
          front_nxt = front_inc;
          count_nxt = cnt_r - CW'(1);
        end
      end
      default: begin
        op.status = STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      cnt_r   <= '0;
    end else if (step) begin
      front_r <= front_nxt;
      cnt_r   <= count_nxt;
    end
  end

  `DEQ_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CW'(DEPTH), "Entry count exceeds depth.")
  `DEQ_ASSERT_NOW(a_front_bound, 1'b1, front_r <= AW'(DEPTH - 1), "Front index out of range.")
  `DEQ_ASSERT_NEXT(a_full_hold, step && full && (mode == MODE_PUSH_BACK || mode == MODE_PUSH_FRONT), $stable(cnt_r) && $stable(front_r), "Refused push changed the state.")
  `DEQ_ASSERT_NEXT(a_pop_dec, step && !empty && (mode == MODE_POP_BACK || mode == MODE_POP_FRONT), cnt_r == $past(cnt_r) - CW'(1), "Pop did not lower the count by one.")

endmodule
